// ----- hdl/wvs_pkg.sv -----
// shared constants, codes and controller/datapath types of the vruntime scheduler
package wvs_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int NICE_LEVELS = 5;
    localparam int WEIGHT_REGS = 5;

    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int CMD_W     = 2;
    localparam int LVL_W     = 3;
    localparam int RT_W      = 32;
    localparam int WEIGHT_W  = 16;
    localparam int TICK_W    = 16;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 3;

    // item commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_PHASE    = 2'd2;
    localparam logic [ST_W-1:0] ST_FINISHED = 2'd3;

    // register indexes: 0 .. WEIGHT_REGS-1 are the weights
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHT_REGS] =
        '{16'd3121, 16'd1991, 16'd1024, 16'd820, 16'd655};
    localparam logic [TICK_W-1:0] TICK_LIMIT_RESET = 16'd10;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START_HEAD,
        OP_START_LVL,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_CAND_RD,
        OP_TICK_CMP,
        OP_WALK_RD,
        OP_WALK_CMP,
        OP_WALK_TAIL,
        OP_TICK_END,
        OP_LOAD_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        GO_RESULT,
        GO_START,
        GO_TICK_ONE,
        GO_TICK
    } accept_go_t;

    typedef struct packed {
        accept_go_t go;
        logic       cand_later;
        logic       walk_end;
        logic       shift_end;
    } dp_sts_t;

endpackage

// ----- hdl/weighted_vruntime_scheduler.sv -----
// top level of the weighted vruntime scheduler
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  input    | in_valid / in_stall        | command, nice_level
//  output   | out_valid / out_stall      | running_id, running_vruntime, finished, status
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  add, refused or finished items: accepted, then loaded into the result register
//  start: takes the queue head as running task, reads its level, then moves each later entry one place toward the head
//  tick: charges the running task; with one task loaded it goes straight to the tick end, else the
//  head is compared with it and the sorted re-insertion walk reads one queue entry and its runtime at a time
//  one item at a time; the next is taken while the result waits in its register
//  reset clears counters and flags and presets config; task tables need no clearing
module weighted_vruntime_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wvs_pkg::CMD_W-1:0]         command,
    input  logic [wvs_pkg::LVL_W-1:0]         nice_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wvs_pkg::ID_W-1:0]          running_id,
    output logic [wvs_pkg::RT_W-1:0]          running_vruntime,
    output logic                              finished,
    output logic [wvs_pkg::ST_W-1:0]          status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wvs_pkg::WEIGHT_W-1:0]      cfg_data
);

    wvs_pkg::dp_op_t  op;
    wvs_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    wvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (op),
        .sts       (sts)
    );

    wvs_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .sts              (sts),
        .command          (command),
        .nice_level       (nice_level),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .running_id       (running_id),
        .running_vruntime (running_vruntime),
        .finished         (finished),
        .status           (status)
    );

endmodule

// ----- hdl/wvs_ram.sv -----
// generic single write port ram with registered read
module wvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/wvs_ctrl.sv -----
// sequencer for item handshake, queue walks and result register
module wvs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output wvs_pkg::dp_op_t  op,
    input  wvs_pkg::dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_HEAD,
        S_START_LVL,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TICK_HEAD,
        S_TICK_CMP,
        S_WALK_RD,
        S_WALK_HEAD,
        S_WALK_CMP,
        S_TICK_END,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op             = wvs_pkg::OP_NONE;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = wvs_pkg::OP_ACCEPT;
                    unique case (sts.go)
                        wvs_pkg::GO_START:    state_next = S_START_HEAD;
                        wvs_pkg::GO_TICK_ONE: state_next = S_TICK_END;
                        wvs_pkg::GO_TICK:     state_next = S_TICK_HEAD;
                        default:              state_next = S_RESULT;
                    endcase
                end
            end
            S_START_HEAD:
            begin
                op         = wvs_pkg::OP_START_HEAD;
                state_next = S_START_LVL;
            end
            S_START_LVL:
            begin
                op         = wvs_pkg::OP_START_LVL;
                state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_end)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    op         = wvs_pkg::OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                op         = wvs_pkg::OP_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_TICK_HEAD:
            begin
                op         = wvs_pkg::OP_CAND_RD;
                state_next = S_TICK_CMP;
            end
            S_TICK_CMP:
            begin
                op         = wvs_pkg::OP_TICK_CMP;
                state_next = sts.cand_later ? S_TICK_END : S_WALK_RD;
            end
            S_WALK_RD:
            begin
                if (sts.walk_end)
                begin
                    op         = wvs_pkg::OP_WALK_TAIL;
                    state_next = S_TICK_END;
                end
                else
                begin
                    op         = wvs_pkg::OP_WALK_RD;
                    state_next = S_WALK_HEAD;
                end
            end
            S_WALK_HEAD:
            begin
                op         = wvs_pkg::OP_CAND_RD;
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                op         = wvs_pkg::OP_WALK_CMP;
                state_next = sts.cand_later ? S_TICK_END : S_WALK_RD;
            end
            S_TICK_END:
            begin
                op         = wvs_pkg::OP_TICK_END;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // result register frees up when empty or taken this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    op             = wvs_pkg::OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside the result state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && in_valid |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start work");

    a_walk_step_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CMP) |=> (state_reg == S_WALK_RD) || (state_reg == S_TICK_END))
        else $error("queue walk left its loop");
`endif

endmodule

// ----- hdl/wvs_dp.sv -----
// datapath: task tables, ready queue, running task, weights and result register
module wvs_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wvs_pkg::dp_op_t                      op,
    output wvs_pkg::dp_sts_t                     sts,
    input  logic [wvs_pkg::CMD_W-1:0]            command,
    input  logic [wvs_pkg::LVL_W-1:0]            nice_level,
    input  logic                                 cfg_write,
    input  logic [wvs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wvs_pkg::WEIGHT_W-1:0]         cfg_data,
    output logic [wvs_pkg::ID_W-1:0]             running_id,
    output logic [wvs_pkg::RT_W-1:0]             running_vruntime,
    output logic                                 finished,
    output logic [wvs_pkg::ST_W-1:0]             status
);

    localparam int ID_W  = wvs_pkg::ID_W;
    localparam int CNT_W = wvs_pkg::CNT_W;
    localparam int LVL_W = wvs_pkg::LVL_W;
    localparam int RT_W  = wvs_pkg::RT_W;

    // control state
    logic [CNT_W-1:0]             count_reg,   count_next;
    logic [ID_W-1:0]              current_reg, current_next;
    logic [RT_W-1:0]              cur_rt_reg,  cur_rt_next;
    logic [LVL_W-1:0]             cur_lvl_reg, cur_lvl_next;
    logic                         started_reg, started_next;
    logic                         done_reg,    done_next;
    logic [wvs_pkg::TICK_W-1:0]   ticks_reg,   ticks_next;
    logic [CNT_W-1:0]             idx_reg,     idx_next;
    logic [wvs_pkg::WEIGHT_W-1:0] weight_reg [wvs_pkg::WEIGHT_REGS];
    logic [wvs_pkg::TICK_W-1:0]   limit_reg;

    // payload
    logic [wvs_pkg::ST_W-1:0]     status_reg,  status_next;
    logic [ID_W-1:0]              cand_reg,    cand_next;
    logic [ID_W-1:0]              ins_id_reg,  ins_id_next;
    logic [RT_W-1:0]              ins_rt_reg,  ins_rt_next;
    logic [ID_W-1:0]              out_id_reg;
    logic [RT_W-1:0]              out_rt_reg;
    logic                         out_fin_reg;
    logic [wvs_pkg::ST_W-1:0]     out_st_reg;

    // memory ports
    logic              rt_we,  lvl_we,  ord_we;
    logic [ID_W-1:0]   rt_waddr, lvl_waddr, ord_waddr, ord_raddr;
    logic [RT_W-1:0]   rt_wdata, rt_q;
    logic [LVL_W-1:0]  lvl_wdata, lvl_q;
    logic [ID_W-1:0]   ord_wdata, ord_q;

    logic [wvs_pkg::WEIGHT_W-1:0] weight;
    logic [RT_W:0]                charge_sum;
    logic [RT_W-1:0]              charged;
    logic [wvs_pkg::TICK_W-1:0]   ticks_inc;
    logic [CNT_W-1:0]             idx_prev;
    logic [LVL_W-1:0]             lvl_clamped;
    logic [wvs_pkg::ST_W-1:0]     acc_status;
    wvs_pkg::accept_go_t          acc_go;
    logic                         acc_add;

    wvs_ram #(.WIDTH(RT_W), .DEPTH(wvs_pkg::MAX_TASKS)) u_rt_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (ord_q),
        .rdata (rt_q)
    );

    wvs_ram #(.WIDTH(LVL_W), .DEPTH(wvs_pkg::MAX_TASKS)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (ord_q),
        .rdata (lvl_q)
    );

    wvs_ram #(.WIDTH(ID_W), .DEPTH(wvs_pkg::MAX_TASKS)) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    // weight of the running task, levels past the last register use the last
    always_comb
    begin
        weight = weight_reg[wvs_pkg::WEIGHT_REGS-1];
        for (int k = 0; k < wvs_pkg::WEIGHT_REGS; k++)
        begin
            if (cur_lvl_reg == LVL_W'(k))
            begin
                weight = weight_reg[k];
            end
        end
    end

    assign charge_sum = {1'b0, cur_rt_reg} + (RT_W + 1)'(weight);
    assign charged    = charge_sum[RT_W] ? {RT_W{1'b1}} : charge_sum[RT_W-1:0];
    assign ticks_inc  = (ticks_reg == {wvs_pkg::TICK_W{1'b1}}) ? ticks_reg
                                                               : ticks_reg + 1'b1;
    assign idx_prev   = idx_reg - CNT_W'(1);
    assign lvl_clamped = (nice_level >= LVL_W'(wvs_pkg::NICE_LEVELS))
                         ? LVL_W'(wvs_pkg::NICE_LEVELS - 1) : nice_level;

    // item decode
    always_comb
    begin
        acc_status = wvs_pkg::ST_OK;
        acc_go     = wvs_pkg::GO_RESULT;
        acc_add    = 1'b0;
        if (done_reg)
        begin
            acc_status = wvs_pkg::ST_FINISHED;
        end
        else
        begin
            unique case (command)
                wvs_pkg::CMD_ADD:
                begin
                    if (started_reg)
                    begin
                        acc_status = wvs_pkg::ST_PHASE;
                    end
                    else if (count_reg >= CNT_W'(wvs_pkg::MAX_TASKS))
                    begin
                        acc_status = wvs_pkg::ST_FULL;
                    end
                    else
                    begin
                        acc_add = 1'b1;
                    end
                end
                wvs_pkg::CMD_START:
                begin
                    if (started_reg || (count_reg == '0))
                    begin
                        acc_status = wvs_pkg::ST_PHASE;
                    end
                    else
                    begin
                        acc_go = wvs_pkg::GO_START;
                    end
                end
                wvs_pkg::CMD_TICK:
                begin
                    if (!started_reg)
                    begin
                        acc_status = wvs_pkg::ST_PHASE;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        acc_go = wvs_pkg::GO_TICK_ONE;
                    end
                    else
                    begin
                        acc_go = wvs_pkg::GO_TICK;
                    end
                end
                default:
                begin
                    acc_status = wvs_pkg::ST_PHASE;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.go         = acc_go;
        sts.cand_later = (rt_q > ins_rt_reg);
        sts.walk_end   = (idx_reg == count_reg - CNT_W'(1));
        sts.shift_end  = (idx_reg == count_reg);
    end

    always_comb
    begin
        count_next   = count_reg;
        current_next = current_reg;
        cur_rt_next  = cur_rt_reg;
        cur_lvl_next = cur_lvl_reg;
        started_next = started_reg;
        done_next    = done_reg;
        ticks_next   = ticks_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        cand_next    = cand_reg;
        ins_id_next  = ins_id_reg;
        ins_rt_next  = ins_rt_reg;

        rt_we     = 1'b0;
        rt_waddr  = current_reg;
        rt_wdata  = charged;
        lvl_we    = 1'b0;
        lvl_waddr = count_reg[ID_W-1:0];
        lvl_wdata = lvl_clamped;
        ord_we    = 1'b0;
        ord_waddr = idx_prev[ID_W-1:0];
        ord_wdata = cand_reg;
        ord_raddr = '0;

        unique case (op)
            wvs_pkg::OP_ACCEPT:
            begin
                status_next = acc_status;
                if (acc_add)
                begin
                    rt_we      = 1'b1;
                    rt_waddr   = count_reg[ID_W-1:0];
                    rt_wdata   = '0;
                    lvl_we     = 1'b1;
                    ord_we     = 1'b1;
                    ord_waddr  = count_reg[ID_W-1:0];
                    ord_wdata  = count_reg[ID_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                if ((acc_go == wvs_pkg::GO_TICK) || (acc_go == wvs_pkg::GO_TICK_ONE))
                begin
                    rt_we       = 1'b1;
                    cur_rt_next = charged;
                    ins_rt_next = charged;
                end
            end
            wvs_pkg::OP_START_HEAD:
            begin
                current_next = ord_q;
                cur_rt_next  = '0;
                started_next = 1'b1;
                idx_next     = CNT_W'(1);
            end
            wvs_pkg::OP_START_LVL:
            begin
                cur_lvl_next = lvl_q;
            end
            wvs_pkg::OP_SHIFT_RD:
            begin
                ord_raddr = idx_reg[ID_W-1:0];
            end
            wvs_pkg::OP_SHIFT_WR:
            begin
                ord_we    = 1'b1;
                ord_wdata = ord_q;
                idx_next  = idx_reg + CNT_W'(1);
            end
            wvs_pkg::OP_CAND_RD:
            begin
                cand_next = ord_q;
            end
            wvs_pkg::OP_TICK_CMP:
            begin
                // head of queue runs next unless it is behind the charged task
                if (!sts.cand_later)
                begin
                    ins_id_next  = current_reg;
                    current_next = cand_reg;
                    cur_rt_next  = rt_q;
                    cur_lvl_next = lvl_q;
                    idx_next     = CNT_W'(1);
                end
            end
            wvs_pkg::OP_WALK_RD:
            begin
                ord_raddr = idx_reg[ID_W-1:0];
            end
            wvs_pkg::OP_WALK_CMP:
            begin
                ord_we = 1'b1;
                if (sts.cand_later)
                begin
                    ord_wdata = ins_id_reg;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            wvs_pkg::OP_WALK_TAIL:
            begin
                ord_we    = 1'b1;
                ord_wdata = ins_id_reg;
            end
            wvs_pkg::OP_TICK_END:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= limit_reg)
                begin
                    rt_we       = 1'b1;
                    cur_rt_next = charged;
                    done_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            current_reg <= '0;
            cur_rt_reg  <= '0;
            cur_lvl_reg <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            ticks_reg   <= '0;
            idx_reg     <= '0;
            limit_reg   <= wvs_pkg::TICK_LIMIT_RESET;
            for (int k = 0; k < wvs_pkg::WEIGHT_REGS; k++)
            begin
                weight_reg[k] <= wvs_pkg::WEIGHT_RESET[k];
            end
        end
        else
        begin
            count_reg   <= count_next;
            current_reg <= current_next;
            cur_rt_reg  <= cur_rt_next;
            cur_lvl_reg <= cur_lvl_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            ticks_reg   <= ticks_next;
            idx_reg     <= idx_next;
            if (cfg_write)
            begin
                for (int k = 0; k < wvs_pkg::WEIGHT_REGS; k++)
                begin
                    if (cfg_index == wvs_pkg::CFG_IDX_W'(k))
                    begin
                        weight_reg[k] <= cfg_data;
                    end
                end
                if (cfg_index == wvs_pkg::REG_TICK_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        cand_reg   <= cand_next;
        ins_id_reg <= ins_id_next;
        ins_rt_reg <= ins_rt_next;
        if (op == wvs_pkg::OP_LOAD_OUT)
        begin
            out_id_reg  <= current_reg;
            out_rt_reg  <= cur_rt_reg;
            out_fin_reg <= done_reg;
            out_st_reg  <= status_reg;
        end
    end

    assign running_id       = out_id_reg;
    assign running_vruntime = out_rt_reg;
    assign finished         = out_fin_reg;
    assign status           = out_st_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(wvs_pkg::MAX_TASKS))
        else $error("task count past table size");

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> started_reg)
        else $error("finished without a running task");

    a_current_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> ({1'b0, current_reg} < count_reg))
        else $error("running task was never loaded");

    a_walk_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (op == wvs_pkg::OP_WALK_RD) |-> (idx_reg < count_reg))
        else $error("queue walk read past the queue");
`endif

endmodule
